>>> rtl/wwdp_pkg.sv
`default_nettype none

package wwdp_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_TIME = 2'd1,
      STATUS_NO_DAY   = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic [1:0] CSR_WEEKDAY_MASK = 2'd0;
   localparam logic [1:0] CSR_WAKE_HOUR    = 2'd1;
   localparam logic [1:0] CSR_WAKE_MINUTE  = 2'd2;
   localparam logic [1:0] CSR_WAKE_SECOND  = 2'd3;

   localparam int unsigned CSR_DATA_W = 7;
   localparam int unsigned SEC_W      = 17;

   localparam logic [4:0] MAX_HOUR   = 5'd23;
   localparam logic [5:0] MAX_MINUTE = 6'd59;
   localparam logic [5:0] MAX_SECOND = 6'd59;
   localparam logic [3:0] LAST_MONTH = 4'd12;

   localparam logic [SEC_W-1:0] SEC_PER_HOUR = 17'd3600;
   localparam logic [SEC_W-1:0] SEC_PER_MIN  = 17'd60;

   // leap test for years 2000 through 2127
   function automatic logic is_leap(input logic [6:0] yic);
      is_leap = (yic[1:0] == 2'b00) && (yic != 7'd100);
   endfunction

   // month length, out of range months count 31 days
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      case (month)
         4'd2:    month_days = leap ? 5'd29 : 5'd28;
         4'd4:    month_days = 5'd30;
         4'd6:    month_days = 5'd30;
         4'd9:    month_days = 5'd30;
         4'd11:   month_days = 5'd30;
         default: month_days = 5'd31;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> rtl/weekly_wake_date_picker_top.sv
// three register stages: stage 1, stage 2 and the output register, in that order
// throughput: one item per cycle through a three stage pipeline while the output is not stalled
// stages: time of day to seconds, weekday search, date roll-over and bcd
// a stalled output holds the pipeline, nothing is dropped or repeated
// reset (synchronous, active high) clears the stage valid bits and all config
`default_nettype none

module weekly_wake_date_picker_top
   import wwdp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   // input items
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [6:0]            req_year_in_century,
   input  wire logic [3:0]            req_cur_month,
   input  wire logic [4:0]            req_cur_day,
   input  wire logic [2:0]            req_cur_weekday,
   input  wire logic [4:0]            req_cur_hour,
   input  wire logic [5:0]            req_cur_minute,
   input  wire logic [5:0]            req_cur_second,
   // result items
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [2:0]                 rsp_days_ahead,
   output logic [3:0]                 rsp_alarm_month,
   output logic [4:0]                 rsp_alarm_day,
   output logic [5:0]                 rsp_alarm_day_bcd
);

   // configuration registers
   logic [6:0] weekday_mask_ff;
   logic [4:0] wake_hour_ff;
   logic [5:0] wake_minute_ff;
   logic [5:0] wake_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weekday_mask_ff <= '0;
         wake_hour_ff    <= '0;
         wake_minute_ff  <= '0;
         wake_second_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WEEKDAY_MASK: weekday_mask_ff <= csr_wr_data[6:0];
            CSR_WAKE_HOUR:    wake_hour_ff    <= csr_wr_data[4:0];
            CSR_WAKE_MINUTE:  wake_minute_ff  <= csr_wr_data[5:0];
            CSR_WAKE_SECOND:  wake_second_ff  <= csr_wr_data[5:0];
            default: ;
         endcase
      end
   end

   // stage enables, a stage loads when empty or when it drains downstream
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_en, s2_en, s3_en;

   assign s3_en     = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   // stage 1: seconds of day, status, month length
   status_type       s1_status_in, s1_status_ff;
   logic [SEC_W-1:0] s1_now_in, s1_now_ff;
   logic [SEC_W-1:0] s1_wake_in, s1_wake_ff;
   logic [4:0]       s1_len_in, s1_len_ff;
   logic [2:0]       s1_wd_ff;
   logic [4:0]       s1_day_ff;
   logic [3:0]       s1_month_ff;

   always_comb begin
      s1_now_in  = SEC_PER_HOUR * {12'd0, req_cur_hour} + SEC_PER_MIN * {11'd0, req_cur_minute}
                 + {11'd0, req_cur_second};
      s1_wake_in = SEC_PER_HOUR * {12'd0, wake_hour_ff} + SEC_PER_MIN * {11'd0, wake_minute_ff}
                 + {11'd0, wake_second_ff};
      s1_len_in  = month_days(req_cur_month, is_leap(req_year_in_century));
      if (weekday_mask_ff == 7'd0) begin
         s1_status_in = STATUS_NO_DAY;
      end else if (wake_hour_ff > MAX_HOUR || wake_minute_ff > MAX_MINUTE ||
                   wake_second_ff > MAX_SECOND) begin
         s1_status_in = STATUS_BAD_TIME;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_status_ff <= s1_status_in;
         s1_now_ff    <= s1_now_in;
         s1_wake_ff   <= s1_wake_in;
         s1_len_ff    <= s1_len_in;
         s1_wd_ff     <= req_cur_weekday;
         s1_day_ff    <= req_cur_day;
         s1_month_ff  <= req_cur_month;
      end
   end

   // stage 2: first enabled weekday, today only while before the wake time
   status_type s2_status_in, s2_status_ff;
   logic [2:0] s2_ahead_in, s2_ahead_ff;
   logic [4:0] s2_day_ff;
   logic [3:0] s2_month_ff;
   logic [4:0] s2_len_ff;

   always_comb begin
      logic       today_ok;
      logic       found;
      logic [3:0] wsum;
      logic [3:0] wmod;
      logic [7:0] hit;
      today_ok = s1_now_ff < s1_wake_ff;
      for (int i = 0; i < 8; i++) begin
         wsum = {1'b0, s1_wd_ff} + 4'(i);
         if (wsum >= 4'd14) begin
            wmod = wsum - 4'd14;
         end else if (wsum >= 4'd7) begin
            wmod = wsum - 4'd7;
         end else begin
            wmod = wsum;
         end
         hit[i] = weekday_mask_ff[wmod[2:0]] && (i != 0 || today_ok);
      end
      found       = |hit;
      s2_ahead_in = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (hit[i]) begin
            s2_ahead_in = 3'(i);
         end
      end
      if (s1_status_ff == STATUS_OK && !found) begin
         s2_status_in = STATUS_NO_DAY;
      end else begin
         s2_status_in = s1_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_status_ff <= s2_status_in;
         s2_ahead_ff  <= s2_ahead_in;
         s2_day_ff    <= s1_day_ff;
         s2_month_ff  <= s1_month_ff;
         s2_len_ff    <= s1_len_ff;
      end
   end

   // stage 3: day and month roll-over, bcd day
   logic [1:0] rsp_status_in, rsp_status_ff;
   logic [2:0] rsp_days_ahead_in, rsp_days_ahead_ff;
   logic [3:0] rsp_alarm_month_in, rsp_alarm_month_ff;
   logic [4:0] rsp_alarm_day_in, rsp_alarm_day_ff;
   logic [5:0] rsp_alarm_day_bcd_in, rsp_alarm_day_bcd_ff;

   always_comb begin
      logic [5:0] nd_sum;
      logic [5:0] nd;
      logic [4:0] nm_sum;
      logic [4:0] nm;
      logic       over;
      logic [1:0] tens;
      logic [4:0] ones;
      nd_sum = {1'b0, s2_day_ff} + {3'd0, s2_ahead_ff};
      over   = nd_sum > {1'b0, s2_len_ff};
      nd     = over ? nd_sum - {1'b0, s2_len_ff} : nd_sum;
      nm_sum = {1'b0, s2_month_ff} + {4'd0, over};
      nm     = (nm_sum > {1'b0, LAST_MONTH}) ? nm_sum - {1'b0, LAST_MONTH} : nm_sum;
      if (nd[4:0] >= 5'd30) begin
         tens = 2'd3;
         ones = nd[4:0] - 5'd30;
      end else if (nd[4:0] >= 5'd20) begin
         tens = 2'd2;
         ones = nd[4:0] - 5'd20;
      end else if (nd[4:0] >= 5'd10) begin
         tens = 2'd1;
         ones = nd[4:0] - 5'd10;
      end else begin
         tens = 2'd0;
         ones = nd[4:0];
      end
      rsp_status_in = s2_status_ff;
      if (s2_status_ff == STATUS_OK) begin
         rsp_days_ahead_in    = s2_ahead_ff;
         rsp_alarm_month_in   = nm[3:0];
         rsp_alarm_day_in     = nd[4:0];
         rsp_alarm_day_bcd_in = {tens, ones[3:0]};
      end else begin
         rsp_days_ahead_in    = '0;
         rsp_alarm_month_in   = '0;
         rsp_alarm_day_in     = '0;
         rsp_alarm_day_bcd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         rsp_status_ff        <= rsp_status_in;
         rsp_days_ahead_ff    <= rsp_days_ahead_in;
         rsp_alarm_month_ff   <= rsp_alarm_month_in;
         rsp_alarm_day_ff     <= rsp_alarm_day_in;
         rsp_alarm_day_bcd_ff <= rsp_alarm_day_bcd_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_days_ahead    = rsp_days_ahead_ff;
   assign rsp_alarm_month   = rsp_alarm_month_ff;
   assign rsp_alarm_day     = rsp_alarm_day_ff;
   assign rsp_alarm_day_bcd = rsp_alarm_day_bcd_ff;

   // error results carry zero date fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_days_ahead == 3'd0 && rsp_alarm_month == 4'd0 &&
         rsp_alarm_day == 5'd0 && rsp_alarm_day_bcd == 6'd0)
      else $error("error result with nonzero date fields");

   // bcd day agrees with the binary day
   a_bcd_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_alarm_day_bcd[3:0] <= 4'd9 &&
         rsp_alarm_day == 5'(rsp_alarm_day_bcd[5:4]) * 5'd10 + 5'(rsp_alarm_day_bcd[3:0]))
      else $error("bcd day does not match alarm day");

   // an accepted item occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item lost at the first stage");

   // a stalled output keeps the rest of the pipeline from advancing into it
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && s2_valid_ff |=> rsp_valid && s2_valid_ff)
      else $error("pipeline advanced under a stall");

endmodule

`default_nettype wire
